@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the set mapper RTL.
// Every check is clocked on clk and is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define XFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication check.
`define XFC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/xfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_pkg
// Widths, constants and shared types of the xor-fold cache set mapper.
// ----------------------------------------------------------------------------
package xfc_pkg;

	localparam int SET_INDEX_BITS = 16;

	// Input word fields
	localparam int TILE_W = 31;
	localparam int CHAN_W = 12;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 4;

	// Result word fields
	localparam int KEY_W   = 51;
	localparam int LOCAL_W = 20;
	localparam int TSIZE_W = 21;

	// Configuration register widths
	localparam int CC_W = 13;
	localparam int KH_W = 5;
	localparam int KW_W = 5;
	localparam int SC_W = 17;

	localparam int IN_DATA_W  = ((TILE_W + CHAN_W + ROW_W + COL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((KEY_W + SET_INDEX_BITS + LOCAL_W + 7) / 8) * 8;
	localparam int ADDR_W     = 4;

	localparam int SET_LIMIT = (SET_INDEX_BITS >= 16) ? 65536 : (1 << SET_INDEX_BITS);
	localparam logic [SC_W-1:0] SET_LIMIT_V = SC_W'(SET_LIMIT);
	localparam logic [CC_W-1:0] CC_MAX = CC_W'(4096);
	localparam logic [KH_W-1:0] KH_MAX = KH_W'(16);
	localparam logic [KW_W-1:0] KW_MAX = KW_W'(16);

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam int MIX_SHIFT  = 33;
	localparam int FOLD_SHIFT = 11;

	// Remainder pipeline: hash bits retired per stage
	localparam int HASH_W         = 32;
	localparam int DIV_STEP_BITS  = 4;
	localparam int DIV_STAGES     = HASH_W / DIV_STEP_BITS;
	localparam int REM_W          = SET_INDEX_BITS;
	localparam int CMP_W          = (REM_W + 1 > SC_W) ? REM_W + 1 : SC_W;

	typedef enum logic [1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_KERNEL_HEIGHT = 2'd1,
		REG_KERNEL_WIDTH  = 2'd2,
		REG_SET_COUNT     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CC_W-1:0] cc;
		logic [KH_W-1:0] kh;
		logic [KW_W-1:0] kw;
		logic [SC_W-1:0] sc;
		logic            ok;
	} cfg_t;

	// Fields that ride alongside the hash through the mixing stages
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LOCAL_W-1:0] local_idx;
		logic               err;
	} side_t;

endpackage

@@ rtl/xfc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_cfg_regs
// APB register file holding the tile geometry and the set count.
// ----------------------------------------------------------------------------
module xfc_cfg_regs import xfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [CC_W-1:0] cc_q;
	logic [KH_W-1:0] kh_q;
	logic [KW_W-1:0] kw_q;
	logic [SC_W-1:0] sc_q;
	reg_idx_t        idx;
	logic            wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_W'(1);
			kh_q <= KH_W'(1);
			kw_q <= KW_W'(1);
			sc_q <= SC_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_CHANNEL_COUNT: cc_q <= pwdata[CC_W-1:0];
				REG_KERNEL_HEIGHT: kh_q <= pwdata[KH_W-1:0];
				REG_KERNEL_WIDTH:  kw_q <= pwdata[KW_W-1:0];
				REG_SET_COUNT:     sc_q <= pwdata[SC_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CHANNEL_COUNT: prdata = 32'(cc_q);
			REG_KERNEL_HEIGHT: prdata = 32'(kh_q);
			REG_KERNEL_WIDTH:  prdata = 32'(kw_q);
			REG_SET_COUNT:     prdata = 32'(sc_q);
		endcase
	end

	assign cfg.cc = cc_q;
	assign cfg.kh = kh_q;
	assign cfg.kw = kw_q;
	assign cfg.sc = sc_q;
	// A register outside its legal range turns every word into a coordinate error.
	assign cfg.ok = (cc_q != '0) && (cc_q <= CC_MAX)
		&& (kh_q != '0) && (kh_q <= KH_MAX)
		&& (kw_q != '0) && (kw_q <= KW_MAX)
		&& (sc_q != '0) && (sc_q <= SET_LIMIT_V);

endmodule

@@ rtl/xfc_key_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_key_calc
// Four-stage front end: range check, local index, line key and xor fold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xfc_key_calc import xfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TILE_W-1:0] tile_number,
	input  logic [CHAN_W-1:0] channel,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  column,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       folded,
	output side_t             side
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// Stage 1
	logic [TILE_W-1:0]  tile_s1;
	logic [CHAN_W-1:0]  chan_s1;
	logic [COL_W-1:0]   col_s1;
	logic [16:0]        a_s1;
	logic [16:0]        ck_s1;
	logic               err_s1;
	// Stage 2
	logic [TILE_W-1:0]  tile_s2;
	logic [LOCAL_W-1:0] local_s2;
	logic [TSIZE_W-1:0] ts_s2;
	logic [43:0]        glo_s2;
	logic [31:0]        ghi_s2;
	logic               err_s2;
	// Stage 3
	logic [KEY_W-1:0]   key_s3;
	logic [63:0]        gch_s3;
	logic [LOCAL_W-1:0] local_s3;
	logic               err_s3;
	// Stage 4
	logic [63:0]        folded_s4;
	side_t              side_s4;

	logic [16:0] a_d;
	logic [16:0] ck_d;
	logic        err_d;
	logic [21:0] local_d;
	logic [21:0] ts_d;
	logic [43:0] ghi_d;
	logic [51:0] key_d;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// (channel * kernel_height + row) and channel_count * kernel_height
	assign a_d   = 17'(channel) * 17'(cfg.kh) + 17'(row);
	assign ck_d  = 17'(cfg.cc) * 17'(cfg.kh);
	assign err_d = !cfg.ok || (CC_W'(channel) >= cfg.cc)
		|| (KH_W'(row) >= cfg.kh) || (KW_W'(column) >= cfg.kw);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			tile_s1 <= tile_number;
			chan_s1 <= channel;
			col_s1  <= column;
			a_s1    <= a_d;
			ck_s1   <= ck_d;
			err_s1  <= err_d;
		end
	end

	assign local_d = 22'(a_s1) * 22'(cfg.kw) + 22'(col_s1);
	assign ts_d    = 22'(ck_s1) * 22'(cfg.kw);
	assign ghi_d   = 44'(chan_s1) * 44'(GOLDEN[63:32]);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			tile_s2  <= tile_s1;
			local_s2 <= local_d[LOCAL_W-1:0];
			ts_s2    <= ts_d[TSIZE_W-1:0];
			glo_s2   <= 44'(chan_s1) * 44'(GOLDEN[31:0]);
			ghi_s2   <= ghi_d[31:0];
			err_s2   <= err_s1;
		end
	end

	assign key_d = 52'(tile_s2) * 52'(ts_s2) + 52'(local_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			key_s3   <= key_d[KEY_W-1:0];
			gch_s3   <= 64'(glo_s2) + {ghi_s2, 32'd0};
			local_s3 <= local_s2;
			err_s3   <= err_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			folded_s4         <= 64'(key_s3) ^ 64'(key_s3 >> FOLD_SHIFT) ^ gch_s3;
			side_s4.key       <= key_s3;
			side_s4.local_idx <= local_s3;
			side_s4.err       <= err_s3;
		end
	end

	assign out_valid = vld_s4;
	assign folded    = folded_s4;
	assign side      = side_s4;

	// With a legal configuration and coordinate, the local index lies inside the tile.
	`XFC_ASSERT_IMPL(a_local_in_tile, vld_s2 && !err_s2, 21'(local_s2) < ts_s2,
		"local index not below tile size")

endmodule

@@ rtl/xfc_mix_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_mix_round
// One finalizer round: xor-shift by 33, then a 64-bit wrapping multiply
// built from three 32-bit partial products over three stages.
// ----------------------------------------------------------------------------
module xfc_mix_round import xfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] mult,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] din,
	input  side_t       side_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] dout,
	output side_t       side_out
);

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [63:0] x_s1, ll_s1;
	side_t       side_s1;
	logic [63:0] x_s2, ll_s2;
	logic [31:0] cr1_s2;
	side_t       side_s2;
	logic [63:0] y_s3;
	side_t       side_s3;

	logic [63:0] x_d;
	logic [31:0] cr1_d;
	logic [31:0] cr2_d;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	assign x_d = din ^ (din >> MIX_SHIFT);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1    <= x_d;
			ll_s1   <= 64'(x_d[31:0]) * 64'(mult[31:0]);
			side_s1 <= side_in;
		end
	end

	// Only the low half of each cross product reaches the 64-bit result.
	assign cr1_d = x_s1[31:0] * mult[63:32];

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			x_s2    <= x_s1;
			ll_s2   <= ll_s1;
			cr1_s2  <= cr1_d;
			side_s2 <= side_s1;
		end
	end

	assign cr2_d = x_s2[63:32] * mult[31:0];

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			y_s3    <= ll_s2 + {cr1_s2 + cr2_d, 32'd0};
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign dout      = y_s3;
	assign side_out  = side_s3;

endmodule

@@ rtl/xfc_set_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_set_mod
// Final xor-shift, then the hash reduced modulo set_count by a restoring
// remainder pipeline that retires four hash bits per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xfc_set_mod import xfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        mixed,
	input  side_t              side_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [REM_W-1:0]   set_index,
	output side_t              side_out
);

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   rdy;
	logic [HASH_W-1:0]     hash_s [DIV_STAGES];
	logic [REM_W-1:0]      rem_s  [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];
	logic [HASH_W-1:0]     hash_in;

	// One restoring step: shift in a hash bit, subtract the divisor if it fits.
	function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
			input logic b, input logic [SC_W-1:0] d);
		logic [CMP_W-1:0] t;
		logic [CMP_W-1:0] dd;
		t  = CMP_W'({r, b});
		dd = CMP_W'(d);
		if (t >= dd) begin
			t = t - dd;
		end
		return t[REM_W-1:0];
	endfunction

	// Low 32 bits of v ^ (v >> 33)
	assign hash_in = mixed[31:0] ^ HASH_W'(mixed[63:MIX_SHIFT]);

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              pv;
		logic [HASH_W-1:0] ph;
		logic [REM_W-1:0]  pr;
		side_t             ps;
		logic [REM_W-1:0]  rem_d;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign ph = hash_in;
			assign pr = '0;
			assign ps = side_in;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign ph = hash_s[k-1];
			assign pr = rem_s[k-1];
			assign ps = side_s[k-1];
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_comb begin
			rem_d = pr;
			for (int i = 0; i < DIV_STEP_BITS; i++) begin
				rem_d = rem_step(rem_d, ph[HASH_W-1-k*DIV_STEP_BITS-i], cfg.sc);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				hash_s[k] <= ph;
				rem_s[k]  <= rem_d;
				side_s[k] <= ps;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign set_index = rem_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

	// A legal word always leaves with a remainder below the set count.
	`XFC_ASSERT_IMPL(a_rem_below_sets, out_valid && !side_out.err,
		CMP_W'(set_index) < CMP_W'(cfg.sc), "set index not below set count")

endmodule

@@ rtl/xor_fold_cache_set_mapper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_fold_cache_set_mapper_core
// Maps a weight coordinate to a cache line key and a hashed set index.
//
//   Port group   Dir   Word
//   s_*          in    tile_number, channel, row, column
//   m_*          out   line_key, set_index, local_index; tuser = coord_error
//   APB          in    channel_count, kernel_height, kernel_width, set_count
//
// One word per cycle in and out while m_tready is high; the pipeline has 4 key stages, two
// 3-stage finalizer rounds (one 32x32 partial product per stage) and 8
// remainder stages of 4 bits each against set_count.
// Reset clears the valid bits; the APB registers reset to 1. No clearing pass.
// Each stage holds its word while the one after it is full and stalled,
// so s_tready stays high as long as any stage has a free slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xor_fold_cache_set_mapper_core import xfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Coordinate stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// tile_number[30:0], channel[42:31], row[46:43], column[50:47], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// line_key[50:0], set_index[66:51], local_index[86:67], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// coord_error[0]
	output logic                  m_tuser
);

	cfg_t               cfg;
	logic [TILE_W-1:0]  tile_number;
	logic [CHAN_W-1:0]  channel;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   column;

	logic               key_valid, key_ready;
	logic [63:0]        key_fold;
	side_t              key_side;
	logic               mix1_valid, mix1_ready;
	logic [63:0]        mix1_data;
	side_t              mix1_side;
	logic               mix2_valid, mix2_ready;
	logic [63:0]        mix2_data;
	side_t              mix2_side;
	logic [REM_W-1:0]   set_rem;
	side_t              out_side;

	assign tile_number = s_tdata[TILE_W-1:0];
	assign channel     = s_tdata[TILE_W+CHAN_W-1:TILE_W];
	assign row         = s_tdata[TILE_W+CHAN_W+ROW_W-1:TILE_W+CHAN_W];
	assign column      = s_tdata[TILE_W+CHAN_W+ROW_W+COL_W-1:TILE_W+CHAN_W+ROW_W];

	xfc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	xfc_key_calc u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.tile_number (tile_number),
		.channel     (channel),
		.row         (row),
		.column      (column),
		.out_valid   (key_valid),
		.out_ready   (key_ready),
		.folded      (key_fold),
		.side        (key_side)
	);

	xfc_mix_round u_mix1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.mult      (MIX_C1),
		.in_valid  (key_valid),
		.in_ready  (key_ready),
		.din       (key_fold),
		.side_in   (key_side),
		.out_valid (mix1_valid),
		.out_ready (mix1_ready),
		.dout      (mix1_data),
		.side_out  (mix1_side)
	);

	xfc_mix_round u_mix2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.mult      (MIX_C2),
		.in_valid  (mix1_valid),
		.in_ready  (mix1_ready),
		.din       (mix1_data),
		.side_in   (mix1_side),
		.out_valid (mix2_valid),
		.out_ready (mix2_ready),
		.dout      (mix2_data),
		.side_out  (mix2_side)
	);

	xfc_set_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mix2_valid),
		.in_ready  (mix2_ready),
		.mixed     (mix2_data),
		.side_in   (mix2_side),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.set_index (set_rem),
		.side_out  (out_side)
	);

	// A flagged word carries all-zero fields.
	assign m_tdata = out_side.err ? '0
		: OUT_DATA_W'({out_side.local_idx, set_rem, out_side.key});
	assign m_tuser = out_side.err;

	// The input side only stalls when the whole pipeline is full behind a stalled output.
	`XFC_ASSERT_IMPL(a_stall_from_output, !s_tready, m_tvalid && !m_tready,
		"input stalled while the pipeline has room")

endmodule
